// ----- design/brms_pkg.sv -----
// ----------------------------------------------------------------------------
// brms_pkg
// Types and constants shared by the block RMS level meter.
// ----------------------------------------------------------------------------
package brms_pkg;

  localparam int unsigned MAX_BLOCK_SAMPLES = 4096;
  localparam int unsigned BLK_LEN_RESET     = 1024;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned SUM_W    = 43;
  localparam int unsigned PROD_W   = 2 * SAMPLE_W;
  localparam int unsigned ROOT_W   = PROD_W / 2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [ROOT_W-1:0]  rms;
    logic [COUNT_W-1:0] block_samples;
  } out_t;

endpackage

// ----- design/block_rms_level_meter.sv -----
// ----------------------------------------------------------------------------
// block_rms_level_meter
// Block RMS meter: sums sample squares, emits floor(sqrt(sum / count)) per block.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | brms_pkg::in_t  (sample, end_of_stream)
//  out_    | output    | out_valid / out_ready | brms_pkg::out_t (rms, block_samples)
//  cfg_    | input     | cfg_valid / cfg_ready | block length, 13 bits
//
//  One sample at a time. A sample that closes no block passes through the
//  shift-add square and the accumulate, then returns to idle.
//  A sample that closes a block then adds restoring division (one quotient
//  bit per cycle), square root (a load, then one root bit per cycle) and a
//  load of the output register, which waits while that register is full.
//  Synchronous active-low reset; block size returns to 1024, sum and count clear.
//  A full output register holds the finished result until out_ready.
// ----------------------------------------------------------------------------
module block_rms_level_meter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  brms_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output brms_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [brms_pkg::COUNT_W-1:0]   cfg_data
);

  localparam int unsigned SW = brms_pkg::SAMPLE_W;
  localparam int unsigned CW = brms_pkg::COUNT_W;
  localparam int unsigned AW = brms_pkg::SUM_W;
  localparam int unsigned PW = brms_pkg::PROD_W;
  localparam int unsigned RW = brms_pkg::ROOT_W;
  localparam int unsigned MUL_STEPS  = SW;
  localparam int unsigned DIV_STEPS  = AW;
  localparam int unsigned SQRT_STEPS = RW;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS + 1);
  localparam int unsigned SREM_W     = RW + 1;
  localparam int unsigned STRY_W     = RW + 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_DIV,
    S_SQRT,
    S_OUT
  } state_t;

  state_t             state_r;
  logic [CW-1:0]      blk_len_r;
  logic [AW-1:0]      sum_r;
  logic [CW-1:0]      count_r;
  logic [SW-1:0]      mcand_r;
  logic [PW-1:0]      prod_r;
  logic               last_r;
  logic [STEP_W-1:0]  step_r;
  logic [CW-1:0]      drem_r;
  logic [AW-1:0]      dq_r;
  logic [SREM_W-1:0]  srem_r;
  logic [RW-1:0]      root_r;
  logic               out_valid_r;
  brms_pkg::out_t     out_data_r;

  logic [SW-1:0]      mag_nxt;
  logic [SW:0]        mul_add_nxt;
  logic [AW-1:0]      sum_nxt;
  logic [CW-1:0]      count_nxt;
  logic [CW-1:0]      eff_size;
  logic               close_nxt;
  logic [CW:0]        div_try;
  logic               div_bit;
  logic [STRY_W-1:0]  sqrt_try;
  logic [STRY_W-1:0]  sqrt_sub;
  logic               sqrt_bit;
  logic               out_load;

  always_comb begin
    mag_nxt     = in_data.sample[SW-1] ? SW'(~in_data.sample + 1'b1) : SW'(in_data.sample);
    mul_add_nxt = {1'b0, prod_r[PW-1:SW]} + (prod_r[0] ? {1'b0, mcand_r} : '0);
    sum_nxt     = sum_r + AW'(prod_r);
    count_nxt   = count_r + 1'b1;
    if (32'(blk_len_r) > brms_pkg::MAX_BLOCK_SAMPLES) begin
      eff_size = CW'(brms_pkg::MAX_BLOCK_SAMPLES);
    end else begin
      eff_size = blk_len_r;
    end
    close_nxt = (count_nxt >= eff_size) || last_r;
    div_try   = {drem_r, dq_r[AW-1]};
    div_bit   = div_try >= {1'b0, count_r};
    sqrt_try  = {srem_r, prod_r[PW-1 -: 2]};
    sqrt_sub  = {1'b0, root_r, 2'b01};
    sqrt_bit  = sqrt_try >= sqrt_sub;
    out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      blk_len_r    <= CW'(brms_pkg::BLK_LEN_RESET);
      sum_r        <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      step_r       <= '0;
    end else begin
      if (cfg_valid) begin
        blk_len_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (blk_len_r == '0) begin
              sum_r   <= '0;
              count_r <= '0;
            end else begin
              mcand_r <= mag_nxt;
              prod_r  <= {{SW{1'b0}}, mag_nxt};
              last_r  <= in_data.end_of_stream;
              step_r  <= '0;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r <= {mul_add_nxt, prod_r[SW-1:1]};
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(MUL_STEPS - 1)) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          count_r <= count_nxt;
          if (close_nxt) begin
            sum_r   <= '0;
            dq_r    <= sum_nxt;
            drem_r  <= '0;
            step_r  <= '0;
            state_r <= S_DIV;
          end else begin
            sum_r   <= sum_nxt;
            state_r <= S_IDLE;
          end
        end
        S_DIV: begin
          drem_r <= div_bit ? CW'(div_try - {1'b0, count_r}) : CW'(div_try);
          dq_r   <= {dq_r[AW-2:0], div_bit};
          if (step_r == STEP_W'(DIV_STEPS - 1)) begin
            step_r  <= '0;
            state_r <= S_SQRT;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_SQRT: begin
          if (step_r == '0) begin
            prod_r <= dq_r[PW-1:0];
            srem_r <= '0;
            root_r <= '0;
            step_r <= step_r + 1'b1;
          end else begin
            srem_r <= sqrt_bit ? SREM_W'(sqrt_try - sqrt_sub) : SREM_W'(sqrt_try);
            root_r <= {root_r[RW-2:0], sqrt_bit};
            prod_r <= {prod_r[PW-3:0], 2'b00};
            step_r <= step_r + 1'b1;
            if (step_r == STEP_W'(SQRT_STEPS)) begin
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_data_r.rms           <= root_r;
            out_data_r.block_samples <= count_r;
            count_r                  <= '0;
            state_r                  <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= brms_pkg::MAX_BLOCK_SAMPLES)
    else $error("sample count beyond block limit");

  a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.block_samples != '0)
    else $error("result with empty block");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.rms <= 16'h8000)
    else $error("rms above full scale");

  a_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && blk_len_r == '0) |=> (in_ready && count_r == '0))
    else $error("disabled meter started work");
`endif

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for block_rms_level_meter. Audio samples are streamed through the
// valid/ready input while a local fixed-point model of the sum of squares,
// the block count and the floor square root predicts each RMS result. The
// results are checked in order. The block size is changed between phases:
// disabled, single-sample, mid-block lowering, a saturating setting and the
// largest legal size, with blocks closed by end of stream. Both sides idle at
// random and the output is held off for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  brms_pkg::in_t                in_data = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  brms_pkg::out_t               out_data;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [brms_pkg::COUNT_W-1:0] cfg_data = '0;

  brms_pkg::in_t                sample_queue[$];
  brms_pkg::out_t               rms_expected[$];
  brms_pkg::out_t               predicted;
  brms_pkg::out_t               observed;

  logic [brms_pkg::COUNT_W-1:0] blk_len_cfg = brms_pkg::COUNT_W'(brms_pkg::BLK_LEN_RESET);
  logic [brms_pkg::SUM_W-1:0]   acc_square_sum = '0;
  logic [brms_pkg::COUNT_W-1:0] acc_count = '0;

  bit in_taken = 1'b0;
  bit pace_fast = 1'b0;
  int in_gap = 0;
  int out_stall = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int samples_queued = 0;
  int samples_taken = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int fail_count = 0;

  block_rms_level_meter DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(0, 9))
      0: return -32768;
      1: return 32767;
      2: return $urandom_range(0, 15) - 8;
      default: return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  // Accumulate one sample; return 1 with the RMS result when a block closes.
  function automatic bit predict_rms(input brms_pkg::in_t item, output brms_pkg::out_t res);
    int              s;
    int              eff;
    longint unsigned mag;
    longint unsigned mean;
    longint unsigned root;
    longint unsigned trial;
    res = '0;
    if (blk_len_cfg == 0) begin
      acc_square_sum = '0;
      acc_count = '0;
      return 1'b0;
    end
    eff = (blk_len_cfg > brms_pkg::MAX_BLOCK_SAMPLES) ? brms_pkg::MAX_BLOCK_SAMPLES
                                                       : blk_len_cfg;
    s = item.sample;
    mag = (s < 0) ? -s : s;
    acc_square_sum = acc_square_sum + brms_pkg::SUM_W'(mag * mag);
    acc_count = acc_count + 1'b1;
    if (acc_count == 0 || (acc_count < eff && !item.end_of_stream)) return 1'b0;
    mean = acc_square_sum / acc_count;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= mean) root = trial;
    end
    res.rms = root[brms_pkg::ROOT_W-1:0];
    res.block_samples = acc_count;
    acc_square_sum = '0;
    acc_count = '0;
    return 1'b1;
  endfunction

  task automatic send(input int s, input bit e);
    brms_pkg::in_t item;
    item.sample = s[brms_pkg::SAMPLE_W-1:0];
    item.end_of_stream = e;
    sample_queue.insert(sample_queue.size(), item);
    samples_queued++;
  endtask

  // Wait for every transfer and result, then let a closing block finish.
  task automatic drain();
    while (samples_taken != samples_queued || rms_expected.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_blk_len(input logic [brms_pkg::COUNT_W-1:0] value);
    int seen;
    seen = cfg_writes;
    @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    while (cfg_writes == seen) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (in_valid && !in_taken) begin
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (sample_queue.size() > 0) begin
      in_data <= sample_queue.pop_front();
      in_valid <= 1'b1;
      in_gap <= pace_fast ? 0 : pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 600;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_stall <= pace_fast ? 0 : pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (cfg_valid && cfg_ready) begin
        blk_len_cfg = cfg_data;
        cfg_writes++;
      end
      if (in_valid && in_ready) begin
        samples_taken++;
        if (predict_rms(in_data, predicted))
          rms_expected.insert(rms_expected.size(), predicted);
      end
      if (out_valid && out_ready) begin
        observed = out_data;
        if (rms_expected.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: rms %0d block_samples %0d",
                     observed.rms, observed.block_samples);
        end else begin
          predicted = rms_expected.pop_front();
          results_checked++;
          if (observed.rms !== predicted.rms ||
              observed.block_samples !== predicted.block_samples) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected rms %0d block_samples %0d, %s %0d %s %0d",
                       predicted.rms, predicted.block_samples,
                       "got rms", observed.rms, "block_samples",
                       observed.block_samples);
          end
        end
      end
    end
  end

  initial begin
    int phase_sizes[12] = '{2, 1, 5, 3, 64, 0, 7, 16, 1, 4, 4096, 9};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send(-32768, 1'b1);
    send(32767, 1'b1);
    send(0, 1'b1);
    send(1, 1'b0);
    send(-1, 1'b1);
    send(-32767, 1'b0);
    send(32767, 1'b0);
    send(-32768, 1'b1);
    drain();
    write_blk_len(0);
    send(-32768, 1'b1);
    send(123, 1'b0);
    drain();
    write_blk_len(1);
    send(-32768, 1'b0);
    send(-1, 1'b0);
    send(0, 1'b1);
    drain();
    write_blk_len(3);
    send(1000, 1'b0);
    send(2000, 1'b0);
    send(3000, 1'b0);
    send(4, 1'b0);
    send(5, 1'b0);
    drain();
    write_blk_len(100);
    send(6, 1'b0);
    send(7, 1'b0);
    send(8, 1'b0);
    drain();
    write_blk_len(2);
    send(9, 1'b0);
    drain();

    pace_fast = 1'b1;
    write_blk_len(8191);
    repeat (60) send(-32768, 1'b0);
    send(100, 1'b1);
    drain();
    write_blk_len(4096);
    repeat (99) send(rand_sample(), 1'b0);
    send(rand_sample(), 1'b1);
    drain();
    pace_fast = 1'b0;

    for (int p = 0; p < 12; p++) begin
      write_blk_len(brms_pkg::COUNT_W'(phase_sizes[p]));
      pace_fast = (p % 4 == 3);
      if (p == 8) hold_req++;
      repeat (35) send(rand_sample(), $urandom_range(0, 7) == 0);
      drain();
    end
    pace_fast = 1'b0;

    $display("%0d samples transferred, %0d RMS results checked, %0d block-size writes",
             samples_taken, results_checked, cfg_writes);
    $display("covered disabled, single-sample, lowered, saturated and 4096 block sizes");
    if (fail_count == 0 && rms_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
